FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with synchronous reset rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked also while reset is high
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/scb_pkg.sv
// ----------------------------------------------------------------------------
// scb_pkg
// types and constants of the slew aware cubic boost
// ----------------------------------------------------------------------------
package scb_pkg;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int GAIN_W = 17;
  localparam int RSC_W  = 16;

  // chase rate in q12.20
  localparam logic [31:0] RATE_FLOOR = 32'd367001600;
  localparam logic [31:0] RATE_CAP   = 32'd2621440000;
  localparam logic [31:0] DECAY_Q30  = 32'd1073634450;
  localparam logic [31:0] DECAY_SUB  = 32'd10486;

  // register indexes
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_RSC  = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DECAY, OP_RATE, OP_GMUL, OP_DIVI, OP_DIVS, OP_DIVE,
    OP_SCALE, OP_SCALED, OP_SQ, OP_A2, OP_CUBE, OP_A3, OP_SLEW, OP_SLEWV,
    OP_BOOST, OP_RES
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } scb_cmd_t;

  typedef struct packed {
    logic div_last;
  } scb_stat_t;

endpackage

FILE: sv/scb_if.sv
// ----------------------------------------------------------------------------
// scb stream interfaces
// valid/ready channels for input and result samples
// ----------------------------------------------------------------------------
interface scb_in_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface scb_out_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

FILE: sv/slew_aware_cubic_boost.sv
// ----------------------------------------------------------------------------
// slew_aware_cubic_boost
// chased trim gain followed by a slew weighted cubic boost and saturation
// ----------------------------------------------------------------------------
// Each sample runs from acceptance to a result in the output register through the
// gain chase, a 64 step bit serial divide and single steps around one shared
// 33x33 multiplier; the sequencer then returns to idle and can take the next
// sample. One sample is in work at a time; a finished result waits in the output
// register while the next sample is taken, and a result that finds the output
// register still full holds the sequencer until it frees.
module slew_aware_cubic_boost import scb_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  scb_in_if.sink      samples,
  scb_out_if.source   results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [GAIN_W-1:0]      gain_target;
  logic [RSC_W-1:0]       rate_scale;
  logic [SAMPLE_BITS-1:0] res;
  scb_cmd_t               cmd;
  scb_stat_t              stat;
  logic                   out_busy;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RSC) ? 32'(rate_scale) : 32'(gain_target);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_target <= GAIN_W'(65536);
      rate_scale  <= RSC_W'(4096);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_GAIN) begin
        gain_target <= pwdata[GAIN_W-1:0];
      end else begin
        rate_scale <= pwdata[RSC_W-1:0];
      end
    end
  end

  assign out_busy = results.valid && !results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      results.sample_out <= res;
    end
  end

  scb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .out_busy (out_busy),
    .stat     (stat),
    .cmd      (cmd)
  );

  scb_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .sample_in   (samples.sample_in),
    .gain_target (gain_target),
    .rate_scale  (rate_scale),
    .res         (res)
  );

`include "assert_macros.svh"

  // a word in work blocks new input for the following cycle
  `ASSERT_CLK(a_busy_after_accept, samples.valid && samples.ready |=> !samples.ready, "input taken twice")
  // output register never overwritten while its word waits
  `ASSERT_CLK(a_no_overwrite, cmd.out_load |-> !results.valid || results.ready, "result overwritten")
  // no result is loaded in the cycle after a sample is taken
  `ASSERT_CLK(a_no_early_load, samples.valid && samples.ready |=> !cmd.out_load, "result too early")

endmodule

FILE: sv/scb_ctrl.sv
// ----------------------------------------------------------------------------
// scb_ctrl
// sequencer stepping the datapath through one sample
// ----------------------------------------------------------------------------
module scb_ctrl import scb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_busy,
  input  scb_stat_t stat,
  output scb_cmd_t  cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DECAY  = 5'd1;
  localparam logic [4:0] ST_RATE   = 5'd2;
  localparam logic [4:0] ST_GMUL   = 5'd3;
  localparam logic [4:0] ST_DIVI   = 5'd4;
  localparam logic [4:0] ST_DIVS   = 5'd5;
  localparam logic [4:0] ST_DIVE   = 5'd6;
  localparam logic [4:0] ST_SCALE  = 5'd7;
  localparam logic [4:0] ST_SCALED = 5'd8;
  localparam logic [4:0] ST_SQ     = 5'd9;
  localparam logic [4:0] ST_A2     = 5'd10;
  localparam logic [4:0] ST_CUBE   = 5'd11;
  localparam logic [4:0] ST_A3     = 5'd12;
  localparam logic [4:0] ST_SLEW   = 5'd13;
  localparam logic [4:0] ST_SLEWV  = 5'd14;
  localparam logic [4:0] ST_BOOST  = 5'd15;
  localparam logic [4:0] ST_RES    = 5'd16;
  localparam logic [4:0] ST_OUT    = 5'd17;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DECAY;
        end
      end
      ST_DECAY:  begin cmd.op = OP_DECAY;  state_next = ST_RATE;   end
      ST_RATE:   begin cmd.op = OP_RATE;   state_next = ST_GMUL;   end
      ST_GMUL:   begin cmd.op = OP_GMUL;   state_next = ST_DIVI;   end
      ST_DIVI:   begin cmd.op = OP_DIVI;   state_next = ST_DIVS;   end
      ST_DIVS: begin
        cmd.op = OP_DIVS;
        if (stat.div_last) begin
          state_next = ST_DIVE;
        end
      end
      ST_DIVE:   begin cmd.op = OP_DIVE;   state_next = ST_SCALE;  end
      ST_SCALE:  begin cmd.op = OP_SCALE;  state_next = ST_SCALED; end
      ST_SCALED: begin cmd.op = OP_SCALED; state_next = ST_SQ;     end
      ST_SQ:     begin cmd.op = OP_SQ;     state_next = ST_A2;     end
      ST_A2:     begin cmd.op = OP_A2;     state_next = ST_CUBE;   end
      ST_CUBE:   begin cmd.op = OP_CUBE;   state_next = ST_A3;     end
      ST_A3:     begin cmd.op = OP_A3;     state_next = ST_SLEW;   end
      ST_SLEW:   begin cmd.op = OP_SLEW;   state_next = ST_SLEWV;  end
      ST_SLEWV:  begin cmd.op = OP_SLEWV;  state_next = ST_BOOST;  end
      ST_BOOST:  begin cmd.op = OP_BOOST;  state_next = ST_RES;    end
      ST_RES:    begin cmd.op = OP_RES;    state_next = ST_OUT;    end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/scb_dp.sv
// ----------------------------------------------------------------------------
// scb_dp
// gain chase, shared multiplier, bit serial divider and boost arithmetic
// ----------------------------------------------------------------------------
module scb_dp import scb_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  scb_cmd_t               cmd,
  output scb_stat_t              stat,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  input  logic [GAIN_W-1:0]      gain_target,
  input  logic [RSC_W-1:0]       rate_scale,
  output logic [SAMPLE_BITS-1:0] res
);

  localparam int N = SAMPLE_BITS;
  localparam int F = N - 1;
  localparam logic [N-1:0] ONE_N = N'(1) << F;
  localparam logic [N-1:0] S_MAX = ONE_N - N'(1);

  // chase state
  logic              primed;
  logic [GAIN_W-1:0] seen;
  logic [31:0]       chase, rate_w, g;

  // per sample work registers
  logic               x_neg;
  logic [N-1:0]       ax, sa, a2, a3, w, scaled, prev;
  logic [N:0]         d;
  logic [PROD_W-1:0]  prod;
  logic [63:0]        num;
  logic [32:0]        rem, den;
  logic [5:0]         cnt;

  logic [MUL_W-1:0]   ma, mb;
  logic [32:0]        rate2, rq, rsub;
  logic [31:0]        rate_new;
  logic [33:0]        rsh;
  logic               ge;
  logic [PROD_W-1:0]  rnd30, rndf;
  logic [PROD_W-31:0] mag;
  logic [N-1:0]       scaled_n, sa_n;
  logic [N:0]         diff, d_n;
  logic [N+1:0]       sum;
  logic [N-1:0]       bm, res_n;
  logic               big;

  assign stat.div_last = (cnt == 6'd0);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_DECAY: begin ma = MUL_W'(rate_w); mb = MUL_W'(DECAY_Q30); end
      OP_GMUL:  begin ma = MUL_W'(g);      mb = MUL_W'(rate_w);    end
      OP_SCALE: begin ma = MUL_W'(ax);     mb = MUL_W'(g);         end
      OP_SQ:    begin ma = MUL_W'(sa);     mb = MUL_W'(sa);        end
      OP_CUBE:  begin ma = MUL_W'(sa);     mb = MUL_W'(a2);        end
      OP_SLEW:  begin ma = MUL_W'(d);      mb = MUL_W'(rate_scale); end
      OP_BOOST: begin ma = MUL_W'(a3);     mb = MUL_W'(w);         end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    // rate doubling on a new setting, then cap
    rate2 = {1'b0, chase};
    if (!primed || seen != gain_target) begin
      rate2 = {chase, 1'b0};
    end
    // decay step from the product
    rq   = prod[62:30];
    rsub = (rq > 33'(DECAY_SUB)) ? rq - 33'(DECAY_SUB) : 33'd0;
    rate_new = (rsub < 33'(RATE_FLOOR)) ? RATE_FLOOR : rsub[31:0];
    // one restoring divide step
    rsh = {rem, num[63]};
    ge  = (rsh >= {1'b0, den});
    // scaled sample with rounding and saturation
    rnd30 = prod + (PROD_W'(1) << 29);
    mag   = rnd30[PROD_W-1:30];
    if (x_neg) begin
      scaled_n = (mag > (PROD_W-30)'(ONE_N)) ? ONE_N : N'(0) - mag[N-1:0];
    end else begin
      scaled_n = (mag > (PROD_W-30)'(S_MAX)) ? S_MAX : mag[N-1:0];
    end
    sa_n = scaled_n[N-1] ? N'(0) - scaled_n : scaled_n;
    diff = {scaled_n[N-1], scaled_n} - {prev[N-1], prev};
    d_n  = diff[N] ? (N+1)'(0) - diff : diff;
    // rounding shift by the fraction width
    rndf = prod + (PROD_W'(1) << (F - 1));
    bm   = rndf[F +: N];
    big  = |prod[PROD_W-1:12+F];
    sum  = {{2{scaled[N-1]}}, scaled}
         + (scaled[N-1] ? (N+2)'(0) - (N+2)'(bm) : (N+2)'(bm));
    if ($signed(sum) > $signed((N+2)'(S_MAX))) begin
      res_n = S_MAX;
    end else if ($signed(sum) < $signed({2'b11, ONE_N})) begin
      res_n = ONE_N;
    end else begin
      res_n = sum[N-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
      seen   <= '0;
      chase  <= RATE_FLOOR;
      g      <= '0;
      prev   <= '0;
      cnt    <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          seen   <= gain_target;
          rate_w <= (rate2 > 33'(RATE_CAP)) ? RATE_CAP : rate2[31:0];
          if (!primed) begin
            g      <= 32'({gain_target, 14'b0});
            primed <= 1'b1;
          end
          x_neg <= sample_in[N-1];
          ax    <= sample_in[N-1] ? N'(0) - sample_in : sample_in;
        end
        OP_RATE: begin
          chase  <= rate_new;
          rate_w <= rate_new;
        end
        OP_DIVI: begin
          num <= prod[63:0] + {13'b0, gain_target, 34'b0};
          den <= {1'b0, rate_w} + 33'(1 << 20);
          rem <= '0;
          cnt <= 6'd63;
        end
        OP_DIVS: begin
          rem <= ge ? 33'(rsh - {1'b0, den}) : rsh[32:0];
          num <= {num[62:0], ge};
          cnt <= cnt - 6'd1;
        end
        OP_DIVE: g <= num[31:0];
        OP_SCALED: begin
          scaled <= scaled_n;
          sa     <= sa_n;
          d      <= d_n;
          prev   <= scaled_n;
        end
        OP_A2: a2 <= bm;
        OP_A3: a3 <= bm;
        OP_SLEWV: w <= big ? '0 : ONE_N - {1'b0, prod[12 +: F]};
        OP_RES: res <= res_n;
        default: ;
      endcase
      unique case (cmd.op)
        OP_DECAY, OP_GMUL, OP_SCALE, OP_SQ, OP_CUBE, OP_SLEW, OP_BOOST:
          prod <= ma * mb;
        default: ;
      endcase
    end
  end

endmodule
